// File: design/vpps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpps_pkg
// Shared types, constants and helpers for the voice prompt pulse sequencer.
// ----------------------------------------------------------------------------
package vpps_pkg;

    // sizing
    localparam int MAX_SEGMENTS = 8;
    localparam int TIMER_BITS   = 16;
    localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int SLOT_COUNT   = 8;

    // fixed voices
    localparam logic [7:0] VOICE_HUNDRED = 8'd39;
    localparam logic [7:0] VOICE_TEN     = 8'd38;
    localparam logic [7:0] VOICE_ONE     = 8'd28;
    localparam logic [7:0] VOICE_TIMES   = 8'd27;

    // request opcodes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SINGLE = 2'd1;
    localparam logic [1:0] OP_PHRASE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_PULSE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_SETTLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHRASE_SETTLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL          = 3'd5;

    // configuration defaults
    localparam logic [CFG_W-1:0] DEF_RESET_PULSE   = 16'd10;
    localparam logic [CFG_W-1:0] DEF_SINGLE_SETTLE = 16'd300;
    localparam logic [CFG_W-1:0] DEF_PHRASE_SETTLE = 16'd500;
    localparam logic [CFG_W-1:0] DEF_PULSE_HIGH    = 16'd10;
    localparam logic [CFG_W-1:0] DEF_PULSE_LOW     = 16'd10;
    localparam logic [CFG_W-1:0] DEF_TAIL          = 16'd100;

    // request class after decode
    typedef enum logic [1:0] {
        K_TICK,
        K_START,
        K_NOP
    } t_kind;

    // one segment: pulse count and wait-after flag
    typedef struct packed {
        logic       wait_after;
        logic [7:0] count;
    } t_seg;

    // decoded request as it travels through the queue
    typedef struct packed {
        t_kind                          kind;
        logic                           single_mode;
        logic                           busy;
        logic [SEG_CNT_W-1:0]           seg_total;
        t_seg [MAX_SEGMENTS-1:0]        segs;
    } t_item;

    // cut or widen a register value to the timer width
    function automatic logic [TIMER_BITS-1:0] f_timer_load(input logic [CFG_W-1:0] v);
        logic [CFG_W+31:0] w;
        w = {32'd0, v};
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

// File: design/vpps_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpps_cmd_if
// Request channel: valid/ready handshake with the command fields.
// ----------------------------------------------------------------------------
interface vpps_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] first_voice;
    logic [7:0] second_voice;
    logic [7:0] hundreds_digit;
    logic [7:0] tens_digit;
    logic [7:0] ones_digit;
    logic [7:0] times_flag;
    logic       busy_level;

    modport source (
        output valid, opcode, first_voice, second_voice, hundreds_digit,
               tens_digit, ones_digit, times_flag, busy_level,
        input  ready
    );

    modport sink (
        input  valid, opcode, first_voice, second_voice, hundreds_digit,
               tens_digit, ones_digit, times_flag, busy_level,
        output ready
    );
endinterface

// File: design/vpps_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpps_res_if
// Result channel: valid/ready handshake with the pin levels and status.
// ----------------------------------------------------------------------------
interface vpps_res_if;
    logic valid;
    logic ready;
    logic reset_line;
    logic data_line;
    logic active;
    logic command_rejected;

    modport source (
        output valid, reset_line, data_line, active, command_rejected,
        input  ready
    );

    modport sink (
        input  valid, reset_line, data_line, active, command_rejected,
        output ready
    );
endinterface

// File: design/voice_prompt_pulse_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_prompt_pulse_sequencer
// Drives a pulse-count voice chip: single voices and multi-segment phrases,
// timed by tick requests.
//
//   channel   dir  handshake        contents
//   i_cmd     in   valid / ready    opcode, voices, digits, times, busy
//   o_res     out  valid / ready    reset/data levels, active, rejected
//   i_cfg_*   in   write enable     six 16-bit timing registers
//
// One request per cycle sustained while results are taken; a request is written
// into the two-entry queue and its result is registered as it leaves the queue,
// so the result is offered from the result register.
// The sequencer takes a request whenever the result register is empty or
// being taken; a stalled result fills the queue, then ready drops.
// Reset is synchronous; timing registers return to their defaults.
// ----------------------------------------------------------------------------
module voice_prompt_pulse_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vpps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vpps_pkg::CFG_W-1:0]      i_cfg_data,
    vpps_cmd_if.sink                        i_cmd,
    vpps_res_if.source                      o_res
);

    logic            q_push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    vpps_pkg::t_item front_item;
    vpps_pkg::t_item q_item;

    // decode and segment build
    vpps_front u_front (
        .cmd      (i_cmd),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (front_item)
    );

    // decoupling queue
    vpps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // sequencer
    vpps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .res        (o_res)
    );

endmodule

// File: design/vpps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpps_front
// Accepts requests, classifies them and builds the phrase segment list.
// ----------------------------------------------------------------------------
module vpps_front (
    vpps_cmd_if.sink         cmd,
    input  logic             i_q_full,
    output logic             o_push,
    output vpps_pkg::t_item  o_item
);

    vpps_pkg::t_seg                     slot_seg [vpps_pkg::SLOT_COUNT];
    logic [vpps_pkg::SLOT_COUNT-1:0]    slot_en;
    logic                               is_single;
    logic [vpps_pkg::SEG_CNT_W-1:0]     cnt;

    // request handshake
    assign cmd.ready = !i_q_full;
    assign o_push    = cmd.valid && !i_q_full;

    assign is_single = (cmd.opcode == vpps_pkg::OP_SINGLE);

    // candidate segments in phrase order
    always_comb begin
        slot_seg[0] = '{wait_after: !is_single, count: cmd.first_voice};
        slot_seg[1] = '{wait_after: 1'b1, count: cmd.second_voice};
        slot_seg[2] = '{wait_after: 1'b1, count: cmd.hundreds_digit};
        slot_seg[3] = '{wait_after: 1'b1, count: vpps_pkg::VOICE_HUNDRED};
        slot_seg[4] = '{wait_after: 1'b1,
                        count: (cmd.tens_digit == 8'd1) ? vpps_pkg::VOICE_ONE
                                                        : cmd.tens_digit};
        slot_seg[5] = '{wait_after: 1'b1, count: vpps_pkg::VOICE_TEN};
        slot_seg[6] = '{wait_after: 1'b1,
                        count: (cmd.ones_digit == 8'd1) ? vpps_pkg::VOICE_ONE
                                                        : cmd.ones_digit};
        slot_seg[7] = '{wait_after: 1'b0, count: vpps_pkg::VOICE_TIMES};

        slot_en[0] = 1'b1;
        slot_en[1] = !is_single && (cmd.second_voice != 8'd0);
        slot_en[2] = !is_single && (cmd.hundreds_digit != 8'd0);
        slot_en[3] = !is_single && (cmd.hundreds_digit != 8'd0);
        slot_en[4] = !is_single && (cmd.tens_digit != 8'd0);
        slot_en[5] = !is_single && (cmd.tens_digit > 8'd1);
        slot_en[6] = !is_single && (cmd.ones_digit != 8'd0);
        slot_en[7] = !is_single && (cmd.times_flag != 8'd0);
    end

    // classify and pack enabled segments to the front of the list
    always_comb begin
        o_item = '0;
        cnt    = '0;
        case (cmd.opcode)
            vpps_pkg::OP_TICK:   o_item.kind = vpps_pkg::K_TICK;
            vpps_pkg::OP_SINGLE,
            vpps_pkg::OP_PHRASE: o_item.kind = vpps_pkg::K_START;
            default:             o_item.kind = vpps_pkg::K_NOP;
        endcase
        o_item.single_mode = is_single;
        o_item.busy        = cmd.busy_level;
        for (int i = 0; i < vpps_pkg::SLOT_COUNT; i++) begin
            if (slot_en[i]) begin
                o_item.segs[cnt[vpps_pkg::SEG_IDX_W-1:0]] = slot_seg[i];
                cnt = cnt + vpps_pkg::SEG_CNT_W'(1);
            end
        end
        o_item.seg_total = cnt;
    end

endmodule

// File: design/vpps_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpps_queue
// Two-entry queue between the request front and the sequencer back.
// ----------------------------------------------------------------------------
module vpps_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vpps_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output vpps_pkg::t_item  o_item
);

    vpps_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // occupancy update
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/vpps_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpps_back
// Pulse sequencer: runs reset, settle, pulse and wait phases per segment
// and registers one result per request.
// ----------------------------------------------------------------------------
module vpps_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vpps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vpps_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_q_valid,
    input  vpps_pkg::t_item                 i_q_item,
    output logic                            o_q_pop,
    vpps_res_if.source                      res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESET,
        PH_SETTLE,
        PH_HIGH,
        PH_LOW,
        PH_TAIL,
        PH_BUSY
    } t_phase;

    // configuration
    logic [vpps_pkg::CFG_W-1:0] r_cfg_reset;
    logic [vpps_pkg::CFG_W-1:0] r_cfg_single;
    logic [vpps_pkg::CFG_W-1:0] r_cfg_phrase;
    logic [vpps_pkg::CFG_W-1:0] r_cfg_high;
    logic [vpps_pkg::CFG_W-1:0] r_cfg_low;
    logic [vpps_pkg::CFG_W-1:0] r_cfg_tail;

    // sequencer state
    t_phase                              r_phase,    n_phase;
    vpps_pkg::t_seg [vpps_pkg::MAX_SEGMENTS-1:0] r_list, n_list;
    logic [vpps_pkg::SEG_CNT_W-1:0]      r_total,    n_total;
    logic [vpps_pkg::SEG_IDX_W-1:0]      r_pos,      n_pos;
    logic [vpps_pkg::TIMER_BITS-1:0]     r_tick,     n_tick;
    logic [7:0]                          r_pulses,   n_pulses;
    logic                                r_single,   n_single;
    logic                                r_cur_wait, n_cur_wait;

    // result register
    logic r_out_valid,  n_out_valid;
    logic r_out_reset,  n_out_reset;
    logic r_out_data,   n_out_data;
    logic r_out_active, n_out_active;
    logic r_out_rej,    n_out_rej;

    logic                                pop;
    logic                                expired;
    logic [vpps_pkg::TIMER_BITS-1:0]     tick_dec;
    logic [vpps_pkg::SEG_CNT_W-1:0]      pos_inc;
    logic                                last_seg;
    vpps_pkg::t_seg                      next_seg;
    logic [7:0]                          pulses_dec;
    logic                                do_end;
    logic                                do_next;
    logic [vpps_pkg::TIMER_BITS-1:0]     ld_reset;
    logic [vpps_pkg::TIMER_BITS-1:0]     ld_settle;
    logic [vpps_pkg::TIMER_BITS-1:0]     ld_high;
    logic [vpps_pkg::TIMER_BITS-1:0]     ld_low;
    logic [vpps_pkg::TIMER_BITS-1:0]     ld_tail;

    // timer loads
    assign ld_reset  = vpps_pkg::f_timer_load(r_cfg_reset);
    assign ld_settle = vpps_pkg::f_timer_load(r_single ? r_cfg_single : r_cfg_phrase);
    assign ld_high   = vpps_pkg::f_timer_load(r_cfg_high);
    assign ld_low    = vpps_pkg::f_timer_load(r_cfg_low);
    assign ld_tail   = vpps_pkg::f_timer_load(r_cfg_tail);

    // tick countdown, zero lasts one tick like one
    assign expired  = (r_tick <= vpps_pkg::TIMER_BITS'(1));
    assign tick_dec = expired ? '0 : r_tick - vpps_pkg::TIMER_BITS'(1);

    // following segment lookup
    assign pos_inc  = vpps_pkg::SEG_CNT_W'(r_pos) + vpps_pkg::SEG_CNT_W'(1);
    assign last_seg = (pos_inc >= r_total);
    assign next_seg = r_list[pos_inc[vpps_pkg::SEG_IDX_W-1:0]];
    assign pulses_dec = (r_pulses != 8'd0) ? r_pulses - 8'd1 : 8'd0;

    // take a request whenever the result slot is free or draining
    assign pop     = i_q_valid && (!r_out_valid || res.ready);
    assign o_q_pop = pop;

    // result outputs
    assign res.valid            = r_out_valid;
    assign res.reset_line       = r_out_reset;
    assign res.data_line        = r_out_data;
    assign res.active           = r_out_active;
    assign res.command_rejected = r_out_rej;

    // next-state logic
    always_comb begin
        n_phase      = r_phase;
        n_list       = r_list;
        n_total      = r_total;
        n_pos        = r_pos;
        n_tick       = r_tick;
        n_pulses     = r_pulses;
        n_single     = r_single;
        n_cur_wait   = r_cur_wait;
        n_out_valid  = r_out_valid && !res.ready;
        n_out_reset  = r_out_reset;
        n_out_data   = r_out_data;
        n_out_active = r_out_active;
        n_out_rej    = r_out_rej;
        do_end       = 1'b0;
        do_next      = 1'b0;

        if (pop) begin
            n_out_rej = 1'b0;
            case (i_q_item.kind)
                vpps_pkg::K_START: begin
                    if (r_phase != PH_IDLE) begin
                        n_out_rej = 1'b1;
                    end else begin
                        n_list     = i_q_item.segs;
                        n_total    = i_q_item.seg_total;
                        n_pos      = '0;
                        n_single   = i_q_item.single_mode;
                        n_pulses   = i_q_item.segs[0].count;
                        n_cur_wait = i_q_item.segs[0].wait_after;
                        n_phase    = PH_RESET;
                        n_tick     = ld_reset;
                    end
                end
                vpps_pkg::K_TICK: begin
                    case (r_phase)
                        PH_RESET: begin
                            n_tick = tick_dec;
                            if (expired) begin
                                n_phase = PH_SETTLE;
                                n_tick  = ld_settle;
                            end
                        end
                        PH_SETTLE: begin
                            n_tick = tick_dec;
                            if (expired) begin
                                if (r_pulses != 8'd0) begin
                                    n_phase = PH_HIGH;
                                    n_tick  = ld_high;
                                end else begin
                                    do_end = 1'b1;
                                end
                            end
                        end
                        PH_HIGH: begin
                            n_tick = tick_dec;
                            if (expired) begin
                                n_phase = PH_LOW;
                                n_tick  = ld_low;
                            end
                        end
                        PH_LOW: begin
                            n_tick = tick_dec;
                            if (expired) begin
                                n_pulses = pulses_dec;
                                if (pulses_dec != 8'd0) begin
                                    n_phase = PH_HIGH;
                                    n_tick  = ld_high;
                                end else begin
                                    do_end = 1'b1;
                                end
                            end
                        end
                        PH_TAIL: begin
                            n_tick = tick_dec;
                            if (expired) begin
                                n_phase = PH_BUSY;
                            end
                        end
                        PH_BUSY: begin
                            if (!i_q_item.busy) begin
                                do_next = 1'b1;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
                default: ;
            endcase

            // segment finished: wait for the chip or move on
            if (do_end) begin
                if (!r_cur_wait) begin
                    do_next = 1'b1;
                end else if (r_cfg_tail == '0) begin
                    n_phase = PH_BUSY;
                end else begin
                    n_phase = PH_TAIL;
                    n_tick  = ld_tail;
                end
            end

            // advance to the following segment or finish
            if (do_next) begin
                n_pos = pos_inc[vpps_pkg::SEG_IDX_W-1:0];
                if (last_seg) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase    = PH_RESET;
                    n_pulses   = next_seg.count;
                    n_cur_wait = next_seg.wait_after;
                    n_tick     = ld_reset;
                end
            end

            n_out_valid  = 1'b1;
            n_out_reset  = (n_phase == PH_RESET);
            n_out_data   = (n_phase == PH_HIGH);
            n_out_active = (n_phase != PH_IDLE);
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_total     <= '0;
            r_pos       <= '0;
            r_tick      <= '0;
            r_pulses    <= '0;
            r_single    <= 1'b0;
            r_cur_wait  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_total     <= n_total;
            r_pos       <= n_pos;
            r_tick      <= n_tick;
            r_pulses    <= n_pulses;
            r_single    <= n_single;
            r_cur_wait  <= n_cur_wait;
            r_out_valid <= n_out_valid;
        end
        r_list       <= n_list;
        r_out_reset  <= n_out_reset;
        r_out_data   <= n_out_data;
        r_out_active <= n_out_active;
        r_out_rej    <= n_out_rej;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_reset  <= vpps_pkg::DEF_RESET_PULSE;
            r_cfg_single <= vpps_pkg::DEF_SINGLE_SETTLE;
            r_cfg_phrase <= vpps_pkg::DEF_PHRASE_SETTLE;
            r_cfg_high   <= vpps_pkg::DEF_PULSE_HIGH;
            r_cfg_low    <= vpps_pkg::DEF_PULSE_LOW;
            r_cfg_tail   <= vpps_pkg::DEF_TAIL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vpps_pkg::CFG_RESET_PULSE:   r_cfg_reset  <= i_cfg_data;
                vpps_pkg::CFG_SINGLE_SETTLE: r_cfg_single <= i_cfg_data;
                vpps_pkg::CFG_PHRASE_SETTLE: r_cfg_phrase <= i_cfg_data;
                vpps_pkg::CFG_PULSE_HIGH:    r_cfg_high   <= i_cfg_data;
                vpps_pkg::CFG_PULSE_LOW:     r_cfg_low    <= i_cfg_data;
                vpps_pkg::CFG_TAIL:          r_cfg_tail   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the voice prompt pulse sequencer against a cycle-free predictor of
// its pin levels. Every accepted request is run through the predictor and
// the expected levels are queued. Each result taken from the block is then
// compared field by field with the oldest queued levels. The run covers
// default, minimum, random small and maximum timing, with directed and
// random requests and random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         HALF_PERIOD      = 5;
    localparam int         RESET_CYCLES     = 7;
    localparam logic [1:0] OP_NOP           = 2'd3;
    localparam int         IDLE_PCT         = 28;
    localparam int         STALL_LIMIT      = 3000;
    localparam int         HOLD_OFF_AT      = 400;
    localparam int         HOLD_OFF_CYCLES  = 300;
    localparam int         RANDOM_ROUNDS    = 3;
    localparam int         ROUND_ITEMS      = 150;
    localparam int         MAX_TIMING_TICKS = 40;
    localparam int         CFG_GAP_CYCLES   = 4;
    localparam int         DRAIN_CYCLES     = 10;

    // sequencer phases as the predictor tracks them
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_RESET,
        SEQ_SETTLE,
        SEQ_HIGH,
        SEQ_LOW,
        SEQ_TAIL,
        SEQ_BUSY
    } t_seq_phase;

    // one request as driven on the command channel
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] first_voice;
        logic [7:0] second_voice;
        logic [7:0] hundreds_digit;
        logic [7:0] tens_digit;
        logic [7:0] ones_digit;
        logic [7:0] times_flag;
        logic       busy_level;
    } t_voice_cmd;

    // pin levels and status after one request
    typedef struct packed {
        logic reset_line;
        logic data_line;
        logic active;
        logic command_rejected;
    } t_pin_levels;

    // ------------------------------------------------------------------------
    // predictor of the sequencer plus the queue of levels still due
    // ------------------------------------------------------------------------
    class voice_pin_scoreboard;
        logic [vpps_pkg::CFG_W-1:0]      reset_pulse;
        logic [vpps_pkg::CFG_W-1:0]      single_settle;
        logic [vpps_pkg::CFG_W-1:0]      phrase_settle;
        logic [vpps_pkg::CFG_W-1:0]      pulse_high;
        logic [vpps_pkg::CFG_W-1:0]      pulse_low;
        logic [vpps_pkg::CFG_W-1:0]      tail_gap;
        t_seq_phase                      phase;
        vpps_pkg::t_seg                  seg_list [vpps_pkg::MAX_SEGMENTS];
        int                              seg_total;
        int                              seg_pos;
        logic [vpps_pkg::TIMER_BITS-1:0] tick_count;
        logic [7:0]                      pulses_left;
        bit                              single_mode;
        t_pin_levels                     levels_due [$];
        int                              errors;
        int                              requests;
        int                              starts;
        int                              phrases;
        int                              rejects;
        int                              checked;

        function new();
            reset_pulse   = vpps_pkg::DEF_RESET_PULSE;
            single_settle = vpps_pkg::DEF_SINGLE_SETTLE;
            phrase_settle = vpps_pkg::DEF_PHRASE_SETTLE;
            pulse_high    = vpps_pkg::DEF_PULSE_HIGH;
            pulse_low     = vpps_pkg::DEF_PULSE_LOW;
            tail_gap      = vpps_pkg::DEF_TAIL;
            phase         = SEQ_IDLE;
            seg_total     = 0;
            seg_pos       = 0;
            tick_count    = '0;
            pulses_left   = '0;
            single_mode   = 1'b0;
            errors        = 0;
            requests      = 0;
            starts        = 0;
            phrases       = 0;
            rejects       = 0;
            checked       = 0;
        endfunction

        function void write_reg(input logic [vpps_pkg::CFG_IDX_W-1:0] idx,
                                input logic [vpps_pkg::CFG_W-1:0] val);
            case (idx)
                vpps_pkg::CFG_RESET_PULSE:   reset_pulse   = val;
                vpps_pkg::CFG_SINGLE_SETTLE: single_settle = val;
                vpps_pkg::CFG_PHRASE_SETTLE: phrase_settle = val;
                vpps_pkg::CFG_PULSE_HIGH:    pulse_high    = val;
                vpps_pkg::CFG_PULSE_LOW:     pulse_low     = val;
                vpps_pkg::CFG_TAIL:          tail_gap      = val;
                default: ;
            endcase
        endfunction

        function bit playing();
            return phase != SEQ_IDLE;
        endfunction

        // a count of zero or one both end on the next tick
        function bit timer_expired();
            if (tick_count <= 1) begin
                tick_count = '0;
                return 1'b1;
            end
            tick_count = tick_count - 1'b1;
            return 1'b0;
        endfunction

        function void add_segment(input logic [7:0] count, input bit hold);
            if (seg_total < vpps_pkg::MAX_SEGMENTS) begin
                seg_list[seg_total].count      = count;
                seg_list[seg_total].wait_after = hold;
                seg_total++;
            end
        endfunction

        function void begin_segment();
            if (seg_pos >= vpps_pkg::MAX_SEGMENTS) begin
                phase = SEQ_IDLE;
                return;
            end
            pulses_left = seg_list[seg_pos].count;
            phase       = SEQ_RESET;
            tick_count  = reset_pulse;
        endfunction

        function void next_segment();
            seg_pos++;
            if (seg_pos >= seg_total)
                phase = SEQ_IDLE;
            else
                begin_segment();
        endfunction

        // segments marked to wait go through the tail gap, if one is set, then watch busy
        function void end_segment();
            bit hold;
            hold = (seg_pos < vpps_pkg::MAX_SEGMENTS) && seg_list[seg_pos].wait_after;
            if (!hold) begin
                next_segment();
            end else if (tail_gap == 0) begin
                phase = SEQ_BUSY;
            end else begin
                phase      = SEQ_TAIL;
                tick_count = tail_gap;
            end
        endfunction

        function void note_request(input t_voice_cmd c);
            t_pin_levels due;
            bit          rejected;
            rejected = 1'b0;
            requests++;
            case (c.opcode)
                // one timing unit passes
                vpps_pkg::OP_TICK: begin
                    case (phase)
                        SEQ_RESET: if (timer_expired()) begin
                            phase      = SEQ_SETTLE;
                            tick_count = single_mode ? single_settle : phrase_settle;
                        end
                        SEQ_SETTLE: if (timer_expired()) begin
                            if (pulses_left != 0) begin
                                phase      = SEQ_HIGH;
                                tick_count = pulse_high;
                            end else begin
                                end_segment();
                            end
                        end
                        SEQ_HIGH: if (timer_expired()) begin
                            phase      = SEQ_LOW;
                            tick_count = pulse_low;
                        end
                        SEQ_LOW: if (timer_expired()) begin
                            if (pulses_left != 0)
                                pulses_left = pulses_left - 1'b1;
                            if (pulses_left != 0) begin
                                phase      = SEQ_HIGH;
                                tick_count = pulse_high;
                            end else begin
                                end_segment();
                            end
                        end
                        SEQ_TAIL: if (timer_expired()) begin
                            phase = SEQ_BUSY;
                        end
                        SEQ_BUSY: if (!c.busy_level) begin
                            next_segment();
                        end
                        default: phase = SEQ_IDLE;
                    endcase
                end
                // start of a single voice or a phrase
                vpps_pkg::OP_SINGLE, vpps_pkg::OP_PHRASE: begin
                    if (phase != SEQ_IDLE) begin
                        rejected = 1'b1;
                        rejects++;
                    end else begin
                        starts++;
                        seg_total = 0;
                        seg_pos   = 0;
                        if (c.opcode == vpps_pkg::OP_SINGLE) begin
                            single_mode = 1'b1;
                            add_segment(c.first_voice, 1'b0);
                        end else begin
                            phrases++;
                            single_mode = 1'b0;
                            add_segment(c.first_voice, 1'b1);
                            if (c.second_voice != 0)
                                add_segment(c.second_voice, 1'b1);
                            if (c.hundreds_digit != 0) begin
                                add_segment(c.hundreds_digit, 1'b1);
                                add_segment(vpps_pkg::VOICE_HUNDRED, 1'b1);
                            end
                            if (c.tens_digit == 1) begin
                                add_segment(vpps_pkg::VOICE_ONE, 1'b1);
                            end else if (c.tens_digit != 0) begin
                                add_segment(c.tens_digit, 1'b1);
                                add_segment(vpps_pkg::VOICE_TEN, 1'b1);
                            end
                            if (c.ones_digit == 1)
                                add_segment(vpps_pkg::VOICE_ONE, 1'b1);
                            else if (c.ones_digit != 0)
                                add_segment(c.ones_digit, 1'b1);
                            if (c.times_flag != 0)
                                add_segment(vpps_pkg::VOICE_TIMES, 1'b0);
                        end
                        begin_segment();
                    end
                end
                default: ;
            endcase
            due.reset_line       = (phase == SEQ_RESET);
            due.data_line        = (phase == SEQ_HIGH);
            due.active           = (phase != SEQ_IDLE);
            due.command_rejected = rejected;
            levels_due.push_back(due);
        endfunction

        function void compare_field(input string name, input logic due, input logic seen);
            if (seen !== due) begin
                $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, due, seen);
                errors++;
            end
        endfunction

        function void check_result(input t_pin_levels seen);
            t_pin_levels due;
            if (levels_due.size() == 0) begin
                $display("%0t: result with no request outstanding", $time);
                errors++;
                return;
            end
            due = levels_due.pop_front();
            checked++;
            compare_field("reset_line", due.reset_line, seen.reset_line);
            compare_field("data_line", due.data_line, seen.data_line);
            compare_field("active", due.active, seen.active);
            compare_field("command_rejected", due.command_rejected, seen.command_rejected);
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [vpps_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [vpps_pkg::CFG_W-1:0]     cfg_data;
    bit                             no_idle;
    bit                             hold_off_done;
    int                             stall_cycles;
    int                             settings_used;

    voice_pin_scoreboard sb = new();

    vpps_cmd_if cmd_bus ();
    vpps_res_if res_bus ();

    voice_prompt_pulse_sequencer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_bus.sink),
        .o_res      (res_bus.source)
    );

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // request with every field random
    function automatic t_voice_cmd random_cmd(input logic [1:0] op);
        t_voice_cmd c;
        c.opcode         = op;
        c.first_voice    = 8'($urandom);
        c.second_voice   = 8'($urandom);
        c.hundreds_digit = 8'($urandom);
        c.tens_digit     = 8'($urandom);
        c.ones_digit     = 8'($urandom);
        c.times_flag     = 8'($urandom);
        c.busy_level     = 1'($urandom);
        return c;
    endfunction

    function automatic t_voice_cmd tick_cmd(input int busy_pct);
        t_voice_cmd c;
        c = random_cmd(vpps_pkg::OP_TICK);
        c.busy_level = ($urandom_range(99) < busy_pct);
        return c;
    endfunction

    function automatic t_voice_cmd build_cmd(input logic [1:0] op, input logic [7:0] v1,
                                             input logic [7:0] v2, input logic [7:0] hun,
                                             input logic [7:0] ten, input logic [7:0] one,
                                             input logic [7:0] tim);
        t_voice_cmd c;
        c.opcode         = op;
        c.first_voice    = v1;
        c.second_voice   = v2;
        c.hundreds_digit = hun;
        c.tens_digit     = ten;
        c.ones_digit     = one;
        c.times_flag     = tim;
        c.busy_level     = 1'b0;
        return c;
    endfunction

    // mostly short voices and the special digit values, rarely anything
    function automatic logic [7:0] pick_voice();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return 8'd0;
        if (roll < 55)
            return 8'd1;
        if (roll < 82)
            return 8'($urandom_range(5, 2));
        if (roll < 97)
            return 8'($urandom_range(12, 6));
        return 8'($urandom);
    endfunction

    function automatic t_voice_cmd start_cmd(input logic [1:0] op);
        t_voice_cmd c;
        c = random_cmd(op);
        c.first_voice = pick_voice();
        if (op == vpps_pkg::OP_PHRASE) begin
            c.second_voice   = pick_voice();
            c.hundreds_digit = pick_voice();
            c.tens_digit     = pick_voice();
            c.ones_digit     = pick_voice();
            c.times_flag     = $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'd0;
        end
        return c;
    endfunction

    // offer one request, after a random gap unless gaps are off, and wait for it to be taken
    task automatic send_cmd(input t_voice_cmd c);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                cmd_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.opcode         <= c.opcode;
        cmd_bus.first_voice    <= c.first_voice;
        cmd_bus.second_voice   <= c.second_voice;
        cmd_bus.hundreds_digit <= c.hundreds_digit;
        cmd_bus.tens_digit     <= c.tens_digit;
        cmd_bus.ones_digit     <= c.ones_digit;
        cmd_bus.times_flag     <= c.times_flag;
        cmd_bus.busy_level     <= c.busy_level;
        do @(posedge i_clk); while (!cmd_bus.ready);
        sb.note_request(c);
    endtask

    // tick until the current voice or phrase has finished
    task automatic play_out(input int busy_pct);
        while (sb.playing())
            send_cmd(tick_cmd(busy_pct));
    endtask

    task automatic cfg_write(input logic [vpps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vpps_pkg::CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // new timing only once every result is back and the block is quiet
    task automatic write_timing(input logic [vpps_pkg::CFG_W-1:0] rst,
                                input logic [vpps_pkg::CFG_W-1:0] ss,
                                input logic [vpps_pkg::CFG_W-1:0] ps,
                                input logic [vpps_pkg::CFG_W-1:0] hi,
                                input logic [vpps_pkg::CFG_W-1:0] lo,
                                input logic [vpps_pkg::CFG_W-1:0] tl);
        cmd_bus.valid <= 1'b0;
        while (sb.levels_due.size() != 0)
            @(posedge i_clk);
        repeat (CFG_GAP_CYCLES) @(posedge i_clk);
        cfg_write(vpps_pkg::CFG_RESET_PULSE, rst);
        cfg_write(vpps_pkg::CFG_SINGLE_SETTLE, ss);
        cfg_write(vpps_pkg::CFG_PHRASE_SETTLE, ps);
        cfg_write(vpps_pkg::CFG_PULSE_HIGH, hi);
        cfg_write(vpps_pkg::CFG_PULSE_LOW, lo);
        cfg_write(vpps_pkg::CFG_TAIL, tl);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // mostly well-formed starts then ticks, with rejected starts and no-ops
    task automatic random_round(input int items);
        t_voice_cmd c;
        int         roll;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(99);
            if (!sb.playing()) begin
                if (roll < 88)
                    c = start_cmd(roll < 30 ? vpps_pkg::OP_SINGLE : vpps_pkg::OP_PHRASE);
                else if (roll < 94)
                    c = random_cmd(vpps_pkg::OP_TICK);
                else
                    c = random_cmd(OP_NOP);
            end else begin
                if (roll < 90)
                    c = tick_cmd(35);
                else if (roll < 96)
                    c = random_cmd($urandom_range(1) ? vpps_pkg::OP_SINGLE
                                                     : vpps_pkg::OP_PHRASE);
                else
                    c = random_cmd(OP_NOP);
            end
            send_cmd(c);
        end
    endtask

    // result side: check each taken result, random stalls, one long hold-off
    always begin
        @(posedge i_clk);
        if (i_rst_n && res_bus.valid && res_bus.ready)
            sb.check_result({res_bus.reset_line, res_bus.data_line, res_bus.active,
                             res_bus.command_rejected});
        if (!hold_off_done && sb.checked >= HOLD_OFF_AT) begin
            res_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            hold_off_done = 1'b1;
        end else begin
            res_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, stall_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial begin
        i_rst_n                <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= vpps_pkg::CFG_RESET_PULSE;
        cfg_data               <= '0;
        cmd_bus.valid          <= 1'b0;
        cmd_bus.opcode         <= vpps_pkg::OP_TICK;
        cmd_bus.first_voice    <= '0;
        cmd_bus.second_voice   <= '0;
        cmd_bus.hundreds_digit <= '0;
        cmd_bus.tens_digit     <= '0;
        cmd_bus.ones_digit     <= '0;
        cmd_bus.times_flag     <= '0;
        cmd_bus.busy_level     <= 1'b0;
        res_bus.ready          <= 1'b0;
        no_idle                = 1'b0;
        hold_off_done          = 1'b0;
        stall_cycles           = 0;
        settings_used          = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default timing: idle tick and no-op, rejected start
        send_cmd(random_cmd(vpps_pkg::OP_TICK));
        send_cmd(random_cmd(OP_NOP));
        send_cmd(build_cmd(vpps_pkg::OP_SINGLE, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(build_cmd(vpps_pkg::OP_PHRASE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                           8'd255));
        send_cmd(random_cmd(OP_NOP));
        play_out(30);

        // minimum timing with no tail gap
        write_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        send_cmd(build_cmd(vpps_pkg::OP_PHRASE, 8'd3, 8'd2, 8'd4, 8'd5, 8'd6, 8'd1));
        play_out(50);
        send_cmd(build_cmd(vpps_pkg::OP_PHRASE, 8'd0, 8'd0, 8'd0, 8'd2, 8'd1, 8'd0));
        play_out(50);
        send_cmd(build_cmd(vpps_pkg::OP_SINGLE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(build_cmd(vpps_pkg::OP_SINGLE, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        play_out(0);
        send_cmd(build_cmd(vpps_pkg::OP_PHRASE, 8'd1, 8'd9, 8'd1, 8'd0, 8'd5, 8'd128));
        play_out(40);
        send_cmd(build_cmd(vpps_pkg::OP_PHRASE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        play_out(50);

        // random rounds under random short timing, the last without gaps
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            write_timing(16'($urandom_range(4, 1)), 16'($urandom_range(6, 1)),
                         16'($urandom_range(6, 1)), 16'($urandom_range(3, 1)),
                         16'($urandom_range(3, 1)), 16'($urandom_range(4, 0)));
            no_idle = (r == RANDOM_ROUNDS - 1);
            random_round(ROUND_ITEMS);
            play_out(35);
            no_idle = 1'b0;
        end

        // maximum timing back to back: a long voice is ticked for a while
        // and a second start is turned away while it runs
        write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        no_idle = 1'b1;
        send_cmd(build_cmd(vpps_pkg::OP_SINGLE, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        repeat (MAX_TIMING_TICKS) send_cmd(tick_cmd(20));
        send_cmd(build_cmd(vpps_pkg::OP_PHRASE, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(random_cmd(OP_NOP));
        no_idle = 1'b0;

        // wait for the last results, then a short quiet stretch
        cmd_bus.valid <= 1'b0;
        while (sb.levels_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d requests, %0d voices started (%0d phrases), %0d starts rejected",
                 sb.requests, sb.starts, sb.phrases, sb.rejects);
        $display("run: %0d results checked over %0d timing settings, %0d mismatches",
                 sb.checked, settings_used + 1, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
